FILE: rtl/mtc_pkg.sv
// ----------------------------------------------------------------------------
// Transport controller package
// Command codes, display modes, limits and shared types of the transport
// controller.
// ----------------------------------------------------------------------------
package mtc_pkg;

    typedef logic [3:0] t_cmd;

    // Commands decoded from the pulse count.
    localparam t_cmd CMD_NONE      = 4'd0;
    localparam t_cmd CMD_PLAY      = 4'd1;
    localparam t_cmd CMD_SEEK_BACK = 4'd2;
    localparam t_cmd CMD_SEEK_FWD  = 4'd3;
    localparam t_cmd CMD_UP        = 4'd4;
    localparam t_cmd CMD_DOWN      = 4'd5;
    localparam t_cmd CMD_OSD       = 4'd6;
    localparam t_cmd CMD_RESTART   = 4'd7;
    localparam t_cmd CMD_MONO      = 4'd8;
    localparam t_cmd CMD_REWIND    = 4'd9;
    localparam t_cmd CMD_STEP      = 4'd10;

    // On-screen display modes.
    localparam logic [1:0] OSD_PLAIN  = 2'd0;
    localparam logic [1:0] OSD_TIME   = 2'd1;
    localparam logic [1:0] OSD_BRIGHT = 2'd2;

    localparam logic [6:0] SEEK_MIN    = 7'd2;
    localparam logic [6:0] SEEK_MAX    = 7'd64;
    localparam logic [7:0] REPEAT_MAX  = 8'd255;
    localparam logic [3:0] LEVEL_MAX   = 4'd15;
    localparam logic [1:0] MUTE_FIELDS = 2'd2;
    localparam logic [3:0] CMD_SAT_16  = 4'd10;

    // Field count and the two values derived from it at write time.
    typedef struct packed {
        logic [31:0] fc;
        logic [31:0] fc_m1;
        logic [31:0] fc_m2;
    } t_count;

    // Field movement requested by the command logic.
    typedef struct packed {
        logic              restart;
        logic              step;
        logic              play_next;
        logic signed [12:0] seek;
    } t_seek_ctl;

    // Player settings after one word.
    typedef struct packed {
        logic       is_playing;
        logic [3:0] volume_level;
        logic [3:0] brightness_level;
        logic [1:0] display_mode;
        logic       mono;
        logic [1:0] mute_left;
        logic [6:0] seek_step;
    } t_settings;

    // Saturate the pulse count to a command code.
    function automatic t_cmd cmd_sat(input logic [15:0] pulses);
        t_cmd c;
        c = (pulses > 16'(CMD_SAT_16)) ? CMD_SAT_16 : pulses[3:0];
        return c;
    endfunction

    // True when the repeat count has reached a nonzero multiple of thirty.
    function automatic logic is_double_point(input logic [7:0] rep);
        logic hit;
        case (rep) inside
            8'd30, 8'd60, 8'd90, 8'd120, 8'd150, 8'd180, 8'd210, 8'd240: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: rtl/mtc_in_if.sv
// ----------------------------------------------------------------------------
// Transport controller input channel
// Valid/ready channel that carries one field-end event word.
// ----------------------------------------------------------------------------
interface mtc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulse_count;
    logic [7:0]  field_rate;
    logic        in_title;

    modport source (output valid, output pulse_count, output field_rate,
                    output in_title, input ready);
    modport sink   (input valid, input pulse_count, input field_rate,
                    input in_title, output ready);
endinterface

FILE: rtl/mtc_out_if.sv
// ----------------------------------------------------------------------------
// Transport controller output channel
// Valid/ready channel that carries one result word per event.
// ----------------------------------------------------------------------------
interface mtc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] field_number;
    logic [31:0] lookahead_field;
    logic        reached_end;
    logic        is_playing;
    logic [3:0]  volume_level;
    logic [3:0]  brightness_level;
    logic [1:0]  display_mode;
    logic        mono;
    logic [1:0]  mute_left;
    logic [6:0]  seek_step;

    modport source (output valid, output field_number, output lookahead_field,
                    output reached_end, output is_playing, output volume_level,
                    output brightness_level, output display_mode, output mono,
                    output mute_left, output seek_step, input ready);
    modport sink   (input valid, input field_number, input lookahead_field,
                    input reached_end, input is_playing, input volume_level,
                    input brightness_level, input display_mode, input mono,
                    input mute_left, input seek_step, output ready);
endinterface

FILE: rtl/mtc_settings.sv
// ----------------------------------------------------------------------------
// Transport controller settings
// Command handling: play state, seek speed, volume, brightness, display mode,
// monochrome and mute countdown.
// ----------------------------------------------------------------------------
module mtc_settings (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_title,
    input  mtc_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_rate,
    input  logic                i_end,
    output mtc_pkg::t_seek_ctl  o_ctl,
    output mtc_pkg::t_settings  o_next
);

    mtc_pkg::t_cmd r_last_cmd, n_last_cmd;
    logic [7:0]    r_repeat, p_repeat, n_repeat;
    logic [6:0]    r_speed, p_speed, n_speed;
    logic [1:0]    r_mute, p_mute, n_mute;
    logic [3:0]    r_volume, n_volume;
    logic [3:0]    r_bright, n_bright;
    logic [1:0]    r_osd, n_osd;
    logic          r_mono, n_mono;
    logic          r_play, n_play;

    logic          fresh;
    logic [7:0]    speed_dbl;
    logic [12:0]   spd_ext;
    logic [12:0]   rate_x10;

    assign fresh    = (i_cmd != r_last_cmd);
    assign speed_dbl = {r_speed, 1'b0};
    assign rate_x10 = {2'b00, i_rate, 3'b000} + {4'b0000, i_rate, 1'b0};

    // Command decode and settings update before the end-of-stream rule.
    always_comb begin
        n_last_cmd = r_last_cmd;
        p_repeat   = r_repeat;
        p_speed    = r_speed;
        p_mute     = r_mute;
        n_volume   = r_volume;
        n_bright   = r_bright;
        n_osd      = r_osd;
        n_mono     = r_mono;
        n_play     = r_play;
        spd_ext    = 13'd0;
        o_ctl      = '0;
        if (i_title) begin
            n_last_cmd = mtc_pkg::CMD_NONE;
        end else begin
            n_last_cmd = i_cmd;
            p_mute = (r_mute != 2'd0) ? r_mute - 2'd1 : r_mute;

            // Seek repeat counting; speed doubles at every thirtieth repeat.
            if (i_cmd == mtc_pkg::CMD_SEEK_BACK || i_cmd == mtc_pkg::CMD_SEEK_FWD) begin
                if (fresh) begin
                    p_repeat = 8'd0;
                    p_speed  = mtc_pkg::SEEK_MIN;
                end else begin
                    p_repeat = (r_repeat != mtc_pkg::REPEAT_MAX) ? r_repeat + 8'd1
                                                                 : r_repeat;
                    if (mtc_pkg::is_double_point(p_repeat)) begin
                        p_speed = (speed_dbl > {1'b0, mtc_pkg::SEEK_MAX}) ?
                                  mtc_pkg::SEEK_MAX : speed_dbl[6:0];
                    end
                end
                spd_ext = {6'd0, p_speed};
                o_ctl.seek = (i_cmd == mtc_pkg::CMD_SEEK_BACK) ? -spd_ext : spd_ext;
            end else begin
                p_repeat = 8'd0;
                p_speed  = mtc_pkg::SEEK_MIN;
            end

            // One-shot commands act only on a change of command.
            if (fresh) begin
                case (i_cmd)
                    mtc_pkg::CMD_PLAY: begin
                        n_play = ~r_play;
                    end
                    mtc_pkg::CMD_UP: begin
                        if (r_osd == mtc_pkg::OSD_BRIGHT) begin
                            if (r_bright != mtc_pkg::LEVEL_MAX) n_bright = r_bright + 4'd1;
                        end else if (r_volume != mtc_pkg::LEVEL_MAX) begin
                            n_volume = r_volume + 4'd1;
                        end
                    end
                    mtc_pkg::CMD_DOWN: begin
                        if (r_osd == mtc_pkg::OSD_BRIGHT) begin
                            if (r_bright != 4'd0) n_bright = r_bright - 4'd1;
                        end else if (r_volume != 4'd0) begin
                            n_volume = r_volume - 4'd1;
                        end
                    end
                    mtc_pkg::CMD_OSD: begin
                        n_osd = (r_osd == mtc_pkg::OSD_BRIGHT) ? mtc_pkg::OSD_PLAIN
                                                               : r_osd + 2'd1;
                    end
                    mtc_pkg::CMD_RESTART: begin
                        o_ctl.restart = 1'b1;
                        n_play        = 1'b1;
                    end
                    mtc_pkg::CMD_MONO: begin
                        n_mono = ~r_mono;
                    end
                    mtc_pkg::CMD_REWIND: begin
                        o_ctl.seek = -rate_x10;
                    end
                    mtc_pkg::CMD_STEP: begin
                        n_play     = 1'b0;
                        o_ctl.step = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            o_ctl.play_next = n_play;
        end
    end

    // Running past the end resets the seek state and mutes audio.
    always_comb begin
        n_repeat = p_repeat;
        n_speed  = p_speed;
        n_mute   = p_mute;
        if (i_end) begin
            n_repeat = 8'd0;
            n_speed  = mtc_pkg::SEEK_MIN;
            n_mute   = mtc_pkg::MUTE_FIELDS;
        end
    end

    assign o_next.is_playing       = n_play;
    assign o_next.volume_level     = n_volume;
    assign o_next.brightness_level = n_bright;
    assign o_next.display_mode     = n_osd;
    assign o_next.mono             = n_mono;
    assign o_next.mute_left        = n_mute;
    assign o_next.seek_step        = n_speed;

    // State registers advance once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd <= mtc_pkg::CMD_NONE;
            r_repeat   <= 8'd0;
            r_speed    <= mtc_pkg::SEEK_MIN;
            r_mute     <= 2'd0;
            r_volume   <= mtc_pkg::LEVEL_MAX;
            r_bright   <= mtc_pkg::LEVEL_MAX;
            r_osd      <= mtc_pkg::OSD_PLAIN;
            r_mono     <= 1'b0;
            r_play     <= 1'b1;
        end else if (i_fire) begin
            r_last_cmd <= n_last_cmd;
            r_repeat   <= n_repeat;
            r_speed    <= n_speed;
            r_mute     <= n_mute;
            r_volume   <= n_volume;
            r_bright   <= n_bright;
            r_osd      <= n_osd;
            r_mono     <= n_mono;
            r_play     <= n_play;
        end
    end

endmodule

FILE: rtl/mtc_field_unit.sv
// ----------------------------------------------------------------------------
// Transport controller field unit
// Holds the current field and works out the next and lookahead fields,
// folding requests before the start or past the end while keeping parity.
// ----------------------------------------------------------------------------
module mtc_field_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_title,
    input  mtc_pkg::t_seek_ctl i_ctl,
    input  mtc_pkg::t_count    i_count,
    output logic [31:0]        o_field,
    output logic [31:0]        o_lookahead,
    output logic               o_end
);

    logic [31:0] r_cur_field;
    logic [33:0] base;
    logic [33:0] req;
    logic [33:0] req_fold;
    logic        ge_end;

    assign base = {2'b00, r_cur_field};

    // Requested field: restart, seek, single step or normal play.
    always_comb begin
        if (i_ctl.restart) begin
            req = 34'd0;
        end else if (i_ctl.seek != 13'sd0) begin
            req = base + {{21{i_ctl.seek[12]}}, i_ctl.seek};
        end else if (i_ctl.step || i_ctl.play_next) begin
            req = base + 34'd1;
        end else begin
            req = base;
        end
    end

    // A negative request lands on field 0 or 1 with the same parity.
    assign req_fold = req[33] ? {33'd0, req[0]} : req;
    assign ge_end   = (req_fold[32:0] >= {1'b0, i_count.fc});

    // A title word gives field 0; past the end it folds to the last two fields, keeping parity.
    always_comb begin
        if (i_title) begin
            o_field = 32'd0;
            o_end   = 1'b0;
        end else if (ge_end) begin
            o_field = i_count.fc_m2 + {31'd0, req_fold[0] ^ i_count.fc[0]};
            o_end   = 1'b1;
        end else begin
            o_field = req_fold[31:0];
            o_end   = 1'b0;
        end
    end

    assign o_lookahead = (o_field == i_count.fc_m1) ? i_count.fc_m2 : o_field + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_field <= 32'd0;
        end else if (i_fire) begin
            r_cur_field <= o_field;
        end
    end

endmodule

FILE: rtl/movie_transport_controller_top.sv
// A word accepted into the input register moves to the result register when
// the result register is free, and is offered on the output from there.
// One word per cycle while the output side is ready; the input register and
// the result register each take a new word whenever the stage after them moves.
// The field update (seek add, end compare and fold) sits between them.
// Reset (i_rst_n low, synchronous) empties both stages, restores the player
// settings and sets the field count to two.
// ----------------------------------------------------------------------------
// Transport controller top level
// Input register, command and field logic, and the result register.
// ----------------------------------------------------------------------------
module movie_transport_controller_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    mtc_in_if.sink       i_in_if,
    mtc_out_if.source    o_out_if
);

    logic               r_in_valid;
    mtc_pkg::t_cmd      r_cmd;
    logic [7:0]         r_rate;
    logic               r_title;

    logic               r_out_valid;
    logic [31:0]        r_out_field;
    logic [31:0]        r_out_look;
    logic               r_out_end;
    mtc_pkg::t_settings r_out_set;

    mtc_pkg::t_count    r_count;
    logic [31:0]        cfg_eff;

    logic               in_accept;
    logic               out_free;
    logic               fire;
    mtc_pkg::t_seek_ctl ctl;
    mtc_pkg::t_settings set_next;
    logic [31:0]        field_next;
    logic [31:0]        look_next;
    logic               end_next;

    // Handshake: the input stage moves when the result register is free.
    assign out_free       = !r_out_valid || o_out_if.ready;
    assign fire           = r_in_valid && out_free;
    assign i_in_if.ready  = !r_in_valid || fire;
    assign in_accept      = i_in_if.valid && i_in_if.ready;

    // Field count register; counts below two act as two.
    assign cfg_eff = (i_cfg_wdata < 32'd2) ? 32'd2 : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count.fc    <= 32'd2;
            r_count.fc_m1 <= 32'd1;
            r_count.fc_m2 <= 32'd0;
        end else if (i_cfg_we) begin
            r_count.fc    <= cfg_eff;
            r_count.fc_m1 <= cfg_eff - 32'd1;
            r_count.fc_m2 <= cfg_eff - 32'd2;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= mtc_pkg::cmd_sat(i_in_if.pulse_count);
            r_rate  <= i_in_if.field_rate;
            r_title <= i_in_if.in_title;
        end
    end

    mtc_settings u_settings (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_title (r_title),
        .i_cmd   (r_cmd),
        .i_rate  (r_rate),
        .i_end   (end_next),
        .o_ctl   (ctl),
        .o_next  (set_next)
    );

    mtc_field_unit u_field (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_title     (r_title),
        .i_ctl       (ctl),
        .i_count     (r_count),
        .o_field     (field_next),
        .o_lookahead (look_next),
        .o_end       (end_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_field <= field_next;
            r_out_look  <= look_next;
            r_out_end   <= end_next;
            r_out_set   <= set_next;
        end
    end

    assign o_out_if.valid            = r_out_valid;
    assign o_out_if.field_number     = r_out_field;
    assign o_out_if.lookahead_field  = r_out_look;
    assign o_out_if.reached_end      = r_out_end;
    assign o_out_if.is_playing       = r_out_set.is_playing;
    assign o_out_if.volume_level     = r_out_set.volume_level;
    assign o_out_if.brightness_level = r_out_set.brightness_level;
    assign o_out_if.display_mode     = r_out_set.display_mode;
    assign o_out_if.mono             = r_out_set.mono;
    assign o_out_if.mute_left        = r_out_set.mute_left;
    assign o_out_if.seek_step        = r_out_set.seek_step;

    // An end fold always restarts the two-field mute and the seek speed.
    a_end_mutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |->
        (r_out_set.mute_left == mtc_pkg::MUTE_FIELDS &&
         r_out_set.seek_step == mtc_pkg::SEEK_MIN))
        else $error("end fold without mute and seek reset");

    // Seek speed is a power of two from two to sixty-four.
    a_seek_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($onehot(r_out_set.seek_step) && !r_out_set.seek_step[0]))
        else $error("seek speed not a power of two");

    // A title word always yields field zero with no end.
    a_title_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_title) |=> (r_out_field == 32'd0 && !r_out_end))
        else $error("title word did not give field zero");

    // A held input word is not lost while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input word dropped during stall");

endmodule

FILE: bench/tb_movie_transport_controller_top.sv
// ----------------------------------------------------------------------------
// Transport controller testbench
// Feeds field-end event words to the transport controller, predicts every
// result word from its own model of the player state, and compares each
// result field by field. Both channels idle at random until the last phase, and
// the field count is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_movie_transport_controller_top;

    // Repeat interval at which the seek speed doubles.
    localparam int DOUBLE_EVERY = 30;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [15:0] pulses;
        logic [7:0]  rate;
        logic        title;
    } t_event;

    typedef struct packed {
        logic [31:0]        field_number;
        logic [31:0]        lookahead_field;
        logic               reached_end;
        mtc_pkg::t_settings settings;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    mtc_in_if  in_ch ();
    mtc_out_if out_ch ();

    movie_transport_controller_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_if     (in_ch),
        .o_out_if    (out_ch)
    );

    // Player state as the block should hold it.
    logic [31:0]   fc_reg;
    logic [31:0]   cur_field;
    mtc_pkg::t_cmd prev_cmd;
    logic [7:0]    repeats;
    logic [6:0]    speed;
    logic [1:0]    mute;
    logic [3:0]    vol;
    logic [3:0]    bright;
    logic [1:0]    osd;
    logic          mono_on;
    logic          play_on;

    t_event  event_queue[$];
    t_result expected_fields[$];
    t_event  drive_word;
    t_result want;

    logic in_taken;
    int   in_gap;
    int   out_stall;
    bit   gaps_on;

    int mismatches;
    int words_sent;
    int words_checked;
    int end_folds;
    int counts_written;
    int top_speed;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #4000000;
        $display("Timeout with %0d results still outstanding.", expected_fields.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Work out the result of one event and advance the player state.
    task automatic transport_step(input t_event ev);
        longint unsigned fc_eff;
        longint unsigned nxt;
        longint unsigned ahead;
        longint          req;
        longint          seek;
        mtc_pkg::t_cmd   cmd;
        logic            fresh;
        logic            restart;
        logic            step;
        logic            at_end;
        t_result         r;
        fc_eff  = (fc_reg < 32'd2) ? 64'd2 : {32'd0, fc_reg};
        restart = 1'b0;
        step    = 1'b0;
        at_end  = 1'b0;
        seek    = 0;
        if (ev.title) begin
            // The title screen parks the player on field zero.
            prev_cmd  = mtc_pkg::CMD_NONE;
            cur_field = '0;
        end else begin
            cmd = (ev.pulses > 16'(mtc_pkg::CMD_STEP)) ? mtc_pkg::CMD_STEP
                                                       : mtc_pkg::t_cmd'(ev.pulses[3:0]);
            if (mute != 2'd0) mute = mute - 2'd1;
            fresh = (cmd != prev_cmd);

            // Seek commands act on every event and speed up while held.
            if (cmd == mtc_pkg::CMD_SEEK_BACK || cmd == mtc_pkg::CMD_SEEK_FWD) begin
                if (fresh) begin
                    repeats = '0;
                    speed   = mtc_pkg::SEEK_MIN;
                end else begin
                    if (repeats != mtc_pkg::REPEAT_MAX) repeats = repeats + 8'd1;
                    if (repeats != 8'd0 && (repeats % DOUBLE_EVERY) == 0)
                        speed = (speed >= mtc_pkg::SEEK_MAX / 2) ? mtc_pkg::SEEK_MAX
                                                                 : speed << 1;
                end
                seek = {57'd0, speed};
                if (cmd == mtc_pkg::CMD_SEEK_BACK) seek = -seek;
            end else begin
                repeats = '0;
                speed   = mtc_pkg::SEEK_MIN;
            end

            // All other commands act only on a change of command.
            if (fresh) begin
                case (cmd)
                    mtc_pkg::CMD_PLAY: play_on = ~play_on;
                    mtc_pkg::CMD_UP: begin
                        if (osd == mtc_pkg::OSD_BRIGHT) begin
                            if (bright != mtc_pkg::LEVEL_MAX) bright = bright + 4'd1;
                        end else if (vol != mtc_pkg::LEVEL_MAX) begin
                            vol = vol + 4'd1;
                        end
                    end
                    mtc_pkg::CMD_DOWN: begin
                        if (osd == mtc_pkg::OSD_BRIGHT) begin
                            if (bright != 4'd0) bright = bright - 4'd1;
                        end else if (vol != 4'd0) begin
                            vol = vol - 4'd1;
                        end
                    end
                    mtc_pkg::CMD_OSD: osd = (osd == mtc_pkg::OSD_BRIGHT) ? mtc_pkg::OSD_PLAIN
                                                                         : osd + 2'd1;
                    mtc_pkg::CMD_RESTART: begin
                        restart = 1'b1;
                        play_on = 1'b1;
                    end
                    mtc_pkg::CMD_MONO: mono_on = ~mono_on;
                    mtc_pkg::CMD_REWIND: seek = -({56'd0, ev.rate} * 10);
                    mtc_pkg::CMD_STEP: begin
                        play_on = 1'b0;
                        step    = 1'b1;
                    end
                    default: ;
                endcase
            end
            prev_cmd = cmd;

            // Requested field, then the parity-keeping fold at either end.
            req = {32'd0, cur_field};
            if (restart) req = 0;
            else if (seek != 0) req = req + seek;
            else if (step || play_on) req = req + 1;
            if (req < 0) req = req & 64'sd1;
            at_end = (req >= fc_eff);
            if (at_end) begin
                nxt     = fc_eff - 2 + ((req - fc_eff) & 64'd1);
                repeats = '0;
                speed   = mtc_pkg::SEEK_MIN;
                mute    = mtc_pkg::MUTE_FIELDS;
                end_folds++;
            end else begin
                nxt = req;
            end
            cur_field = nxt[31:0];
        end
        if (int'(speed) > top_speed) top_speed = speed;

        ahead = {32'd0, cur_field} + 1;
        if (ahead >= fc_eff) ahead = fc_eff - 2;

        r.field_number              = cur_field;
        r.lookahead_field           = ahead[31:0];
        r.reached_end               = at_end;
        r.settings.is_playing       = play_on;
        r.settings.volume_level     = vol;
        r.settings.brightness_level = bright;
        r.settings.display_mode     = osd;
        r.settings.mono             = mono_on;
        r.settings.mute_left        = mute;
        r.settings.seek_step        = speed;
        expected_fields.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            if (mismatches < REPORT_LIMIT)
                $display("Result %0d: %s expected 0x%08h, got 0x%08h",
                         words_checked, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    function automatic void push_event(input logic [15:0] p, input logic [7:0] r,
                                       input logic t);
        t_event ev;
        ev.pulses = p;
        ev.rate   = r;
        ev.title  = t;
        event_queue.push_back(ev);
    endfunction

    // Input monitor: note acceptance and predict the result of each word.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            drive_word.pulses = in_ch.pulse_count;
            drive_word.rate   = in_ch.field_rate;
            drive_word.title  = in_ch.in_title;
            transport_step(drive_word);
            words_sent++;
        end
    end

    // Input driver: present queued words with random idle bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // The word waits until the block takes it.
        end else if (in_gap != 0) begin
            in_ch.valid <= 1'b0;
            in_gap      <= in_gap - 1;
        end else if (event_queue.size() != 0) begin
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                in_ch.valid <= 1'b0;
                in_gap      <= $urandom_range(0, 3);
            end else begin
                in_ch.valid       <= 1'b1;
                in_ch.pulse_count <= event_queue[0].pulses;
                in_ch.field_rate  <= event_queue[0].rate;
                in_ch.in_title    <= event_queue[0].title;
                event_queue.pop_front();
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Output driver: ready with random stall bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_stall != 0) begin
            out_ch.ready <= 1'b0;
            out_stall    <= out_stall - 1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            out_stall    <= $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Output monitor: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_fields.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("Unexpected result word: field 0x%08h",
                             out_ch.field_number);
                mismatches++;
            end else begin
                want = expected_fields.pop_front();
                check_field("field_number", want.field_number, out_ch.field_number);
                check_field("lookahead_field", want.lookahead_field,
                            out_ch.lookahead_field);
                check_field("reached_end", 32'(want.reached_end), 32'(out_ch.reached_end));
                check_field("is_playing", 32'(want.settings.is_playing),
                            32'(out_ch.is_playing));
                check_field("volume_level", 32'(want.settings.volume_level),
                            32'(out_ch.volume_level));
                check_field("brightness_level", 32'(want.settings.brightness_level),
                            32'(out_ch.brightness_level));
                check_field("display_mode", 32'(want.settings.display_mode),
                            32'(out_ch.display_mode));
                check_field("mono", 32'(want.settings.mono), 32'(out_ch.mono));
                check_field("mute_left", 32'(want.settings.mute_left),
                            32'(out_ch.mute_left));
                check_field("seek_step", 32'(want.settings.seek_step),
                            32'(out_ch.seek_step));
                words_checked++;
            end
        end
    end

    // Wait until every queued word has gone in and every result has come out.
    task automatic wait_drained;
        while (event_queue.size() != 0 || in_ch.valid || expected_fields.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_field_count(input logic [31:0] count);
        wait_drained();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        fc_reg     = count;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        counts_written++;
    endtask

    // Random traffic: mostly command runs as a remote would send them,
    // plus setting sweeps, title screens and raw pulse counts.
    task automatic queue_random_events(input int budget, input bit long_runs);
        int            left;
        int            pick;
        int            run;
        int            k;
        mtc_pkg::t_cmd cmd;
        logic [15:0]   p;
        left = budget;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                push_event(16'($urandom), 8'($urandom), 1'($urandom));
                left--;
            end else if (pick < 9) begin
                push_event(16'($urandom), 8'($urandom), 1'b1);
                left--;
            end else if (pick < 17) begin
                // Repeated level changes can reach the saturation limits.
                cmd = $urandom_range(0, 1) ? mtc_pkg::CMD_UP : mtc_pkg::CMD_DOWN;
                run = 2 * $urandom_range(2, 9);
                for (k = 0; k < run && left > 0; k++) begin
                    push_event((k % 2 == 0) ? 16'(cmd) : 16'(mtc_pkg::CMD_NONE),
                               8'($urandom), 1'b0);
                    left--;
                end
            end else begin
                cmd = mtc_pkg::t_cmd'($urandom_range(0, 10));
                if (cmd == mtc_pkg::CMD_SEEK_BACK || cmd == mtc_pkg::CMD_SEEK_FWD)
                    run = (long_runs && $urandom_range(0, 1) == 0) ?
                          $urandom_range(150, 300) : $urandom_range(1, 40);
                else
                    run = $urandom_range(1, 3);
                for (k = 0; k < run && left > 0; k++) begin
                    p = 16'(cmd);
                    if (cmd == mtc_pkg::CMD_STEP && $urandom_range(0, 1) == 1)
                        p = 16'($urandom_range(10, 65535));
                    push_event(p, ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom), 1'b0);
                    left--;
                end
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        int k;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.pulse_count = '0;
        in_ch.field_rate  = '0;
        in_ch.in_title    = 1'b0;
        out_ch.ready      = 1'b0;
        in_taken          = 1'b0;
        in_gap            = 0;
        out_stall         = 0;
        gaps_on           = 1'b1;
        mismatches        = 0;
        words_sent        = 0;
        words_checked     = 0;
        end_folds         = 0;
        counts_written    = 0;
        top_speed         = 0;

        // Player state after reset.
        fc_reg    = 32'd2;
        cur_field = '0;
        prev_cmd  = mtc_pkg::CMD_NONE;
        repeats   = '0;
        speed     = mtc_pkg::SEEK_MIN;
        mute      = '0;
        vol       = mtc_pkg::LEVEL_MAX;
        bright    = mtc_pkg::LEVEL_MAX;
        osd       = mtc_pkg::OSD_PLAIN;
        mono_on   = 1'b0;
        play_on   = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every command, level limits, display modes, rewind past
        // the start, zero rate, saturated pulse counts and the title screen.
        write_field_count(32'd24);
        push_event(16'(mtc_pkg::CMD_NONE), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_PLAY), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_PLAY), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_NONE), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_PLAY), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_UP), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_DOWN), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_OSD), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_NONE), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_OSD), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_UP), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_DOWN), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_OSD), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_MONO), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_REWIND), 8'd255, 1'b0);
        push_event(16'(mtc_pkg::CMD_NONE), 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_REWIND), 8'd0, 1'b0);
        push_event(16'hFFFF, 8'd0, 1'b0);
        push_event(16'd11, 8'd0, 1'b0);
        push_event(16'(mtc_pkg::CMD_RESTART), 8'd0, 1'b0);
        for (k = 0; k < 3; k++) push_event(16'(mtc_pkg::CMD_SEEK_FWD), 8'd3, 1'b0);
        push_event(16'hFFFF, 8'd255, 1'b1);
        push_event(16'(mtc_pkg::CMD_SEEK_BACK), 8'd0, 1'b0);

        // Random phases over small, odd, large and shrunken field counts.
        write_field_count(32'd0);
        queue_random_events(120, 1'b0);
        write_field_count(32'd1);
        queue_random_events(120, 1'b0);
        write_field_count(32'd3);
        queue_random_events(160, 1'b0);
        write_field_count(32'd2);
        queue_random_events(120, 1'b0);
        write_field_count(32'd97);
        queue_random_events(250, 1'b0);

        // A sustained forward seek walks the speed up to its cap and leaves
        // the field well beyond the count written next.
        write_field_count(32'd100000);
        for (k = 0; k < 280; k++)
            push_event(16'(mtc_pkg::CMD_SEEK_FWD), 8'($urandom), 1'b0);
        queue_random_events(250, 1'b1);
        write_field_count(32'd37);
        queue_random_events(150, 1'b0);
        write_field_count(32'hFFFF_FFFF);
        queue_random_events(250, 1'b1);

        // Last phase runs without idle cycles on either side.
        write_field_count(32'd5000);
        gaps_on = 1'b0;
        queue_random_events(250, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_fields.size() != 0) begin
            $display("%0d predicted results never arrived.", expected_fields.size());
            mismatches++;
        end

        $display("Checked %0d results from %0d events under %0d field counts.",
                 words_checked, words_sent, counts_written);
        $display("%0d events folded at the end; seek speed peaked at %0d.",
                 end_folds, top_speed);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mtc_pkg.sv
rtl/mtc_in_if.sv
rtl/mtc_out_if.sv
rtl/mtc_settings.sv
rtl/mtc_field_unit.sv
rtl/movie_transport_controller_top.sv
bench/tb_movie_transport_controller_top.sv
